// ----- hw/rtl/dedupe_priority_prompt_queue_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the prompt queue core
// Short forms for clocked implications masked while reset is high.
// ---------------------------------------------------------------------------
`ifndef DEDUPE_PRIORITY_PROMPT_QUEUE_CORE_ASSERT_SVH
`define DEDUPE_PRIORITY_PROMPT_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define DPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dpq_pkg.sv -----
// ---------------------------------------------------------------------------
// dpq_pkg
// Types and codes shared by the prompt queue core and its slot cells.
// ---------------------------------------------------------------------------
package dpq_pkg;

   localparam int KEY_W  = 64;
   localparam int ID_W   = 8;
   localparam int CODE_W = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NET_REQUIRED  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NET_CONNECTED = 1'b1;

   localparam logic [ID_W-1:0] NET_REQUIRED_RESET  = 8'd1;
   localparam logic [ID_W-1:0] NET_CONNECTED_RESET = 8'd2;

   typedef enum logic [2:0] {
      FUNC_SUBMIT   = 3'd0,
      FUNC_TAKE     = 3'd1,
      FUNC_DONE     = 3'd2,
      FUNC_SET_CONV = 3'd3,
      FUNC_SET_NET  = 3'd4,
      FUNC_QUERY    = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_PENDING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [ID_W-1:0]   prompt_id;
      logic [KEY_W-1:0]  key;
      logic              flag_value;
      logic [CODE_W-1:0] play_result;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              grant_valid;
      logic [ID_W-1:0]   grant_id;
      logic [KEY_W-1:0]  grant_key;
      logic [CODE_W-1:0] result_code;
      logic              busy_res;
   } rsp_type;

   // broadcast to every cell for the beat under way
   typedef struct packed {
      logic            take;
      logic            conv;
      logic            link;
      logic [ID_W-1:0] req_id;
      logic [ID_W-1:0] conn_id;
      logic [ID_W-1:0] prompt_id;
   } cell_cmd_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic            valid;
      logic            hit;
      logic            free_found;
      logic            sel_found;
      logic [ID_W-1:0] sel_id;
   } carry_type;

   typedef struct packed {
      logic set;
      logic clr;
   } cell_wr_type;

endpackage

// ----- hw/rtl/dpq_cell.sv -----
// ---------------------------------------------------------------------------
// dpq_cell
// One queue slot: holds id and key, folds itself into the passing carry.
// ---------------------------------------------------------------------------
module dpq_cell import dpq_pkg::*; #(
   parameter int KEY_BITS = 64,
   parameter int IDX_W    = 3,
   parameter int IDX      = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_cmd_type        cmd,
   input  logic [KEY_BITS-1:0] cmd_key,
   input  carry_type           cin,
   input  logic [IDX_W-1:0]    cin_free_idx,
   input  logic [IDX_W-1:0]    cin_sel_idx,
   input  logic [KEY_BITS-1:0] cin_sel_key,
   output carry_type           cout,
   output logic [IDX_W-1:0]    cout_free_idx,
   output logic [IDX_W-1:0]    cout_sel_idx,
   output logic [KEY_BITS-1:0] cout_sel_key,
   input  cell_wr_type         wr,
   input  logic [IDX_W-1:0]    wr_idx,
   output logic                used
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                used_ff, used_in;
   logic [ID_W-1:0]     id_ff;
   logic [KEY_BITS-1:0] key_ff;

   carry_type           carry_ff, carry_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    sel_idx_ff, sel_idx_in;
   logic [KEY_BITS-1:0] sel_key_ff, sel_key_in;

   logic is_req, is_conn, relevant, eligible, take_me, wr_me;

   always_comb begin
      is_req   = (id_ff == cmd.req_id);
      is_conn  = (id_ff == cmd.conn_id);
      // required id is tested before connected id
      relevant = is_req ? !cmd.link : (is_conn ? cmd.link : 1'b1);
      eligible = used_ff && relevant && !(cmd.conv && (is_req || is_conn));
      take_me  = eligible && (!cin.sel_found || (id_ff > cin.sel_id));
      wr_me    = (wr_idx == MY_IDX);

      carry_in.valid      = cin.valid;
      carry_in.hit        = cin.hit || (used_ff && (key_ff == cmd_key));
      carry_in.free_found = cin.free_found || !used_ff;
      carry_in.sel_found  = cin.sel_found || take_me;
      carry_in.sel_id     = take_me ? id_ff : cin.sel_id;
      free_idx_in = cin.free_found ? cin_free_idx : MY_IDX;
      sel_idx_in  = take_me ? MY_IDX : cin_sel_idx;
      sel_key_in  = take_me ? key_ff : cin_sel_key;

      used_in = used_ff;
      if (cin.valid && cmd.take && used_ff && !relevant) begin
         used_in = 1'b0;   // stale network prompt dropped as the sweep passes
      end else if (wr.set && wr_me) begin
         used_in = 1'b1;
      end else if (wr.clr && wr_me) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         carry_ff <= '0;
      end else begin
         used_ff  <= used_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      sel_idx_ff  <= sel_idx_in;
      sel_key_ff  <= sel_key_in;
      if (wr.set && wr_me) begin
         id_ff  <= cmd.prompt_id;
         key_ff <= cmd_key;
      end
   end

   assign cout          = carry_ff;
   assign cout_free_idx = free_idx_ff;
   assign cout_sel_idx  = sel_idx_ff;
   assign cout_sel_key  = sel_key_ff;
   assign used          = used_ff;

endmodule

// ----- hw/rtl/dedupe_priority_prompt_queue_core.sv -----
// ---------------------------------------------------------------------------
// dedupe_priority_prompt_queue_core
// Deduplicating priority queue of pending prompts built as a chain of slots.
// ---------------------------------------------------------------------------
//  channel   | ports                          | handshake
//  ----------+--------------------------------+------------------------------
//  command   | start, busy, req_data          | beat when start & !busy
//  result    | rsp_valid, rsp_data            | one-cycle strobe, no stall
//  registers | csr_we, csr_index, csr_wdata   | write when csr_we
//
//  For each command a carry walks down the slot chain one cell per cycle,
//  the tail result is applied, and the result is shown for one cycle,
//  during which the next command is taken.
//  Reset (synchronous) empties every slot, clears flags and the last result,
//  and loads the register defaults.
//  The result side has no ready; rsp_valid lasts exactly one cycle.
// ---------------------------------------------------------------------------
`include "dedupe_priority_prompt_queue_core_assert.svh"

module dedupe_priority_prompt_queue_core import dpq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int KEY_BITS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   state_type state_ff, state_in;
   req_type   cmd_ff;
   logic      seed_ff;

   logic [ID_W-1:0]     net_req_ff, net_conn_ff;
   logic                conv_ff, conv_in, link_ff, link_in;
   logic                playing_ff, playing_in;
   logic [KEY_BITS-1:0] playing_tag_ff, playing_tag_in;
   logic                last_valid_ff, last_valid_in;
   logic [KEY_BITS-1:0] last_tag_ff, last_tag_in;
   logic [CODE_W-1:0]   last_code_ff, last_code_in;

   logic [1:0]          status_ff, status_in;
   logic                gvalid_ff, gvalid_in;
   logic [ID_W-1:0]     gid_ff, gid_in;
   logic [KEY_W-1:0]    gkey_ff, gkey_in;
   logic [CODE_W-1:0]   rcode_ff, rcode_in;

   logic                accept, commit, pending;
   logic [KEY_BITS-1:0] cmd_key;
   cell_cmd_type        cell_cmd;
   cell_wr_type         cell_wr;
   logic [IDX_W-1:0]    wr_idx;
   logic [QUEUE_DEPTH-1:0] used_vec;

   carry_type           c_in [QUEUE_DEPTH];
   logic [IDX_W-1:0]    fi_in [QUEUE_DEPTH];
   logic [IDX_W-1:0]    si_in [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] sk_in [QUEUE_DEPTH];
   carry_type           c_out [QUEUE_DEPTH];
   logic [IDX_W-1:0]    fi_out [QUEUE_DEPTH];
   logic [IDX_W-1:0]    si_out [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] sk_out [QUEUE_DEPTH];
   carry_type           tail;
   carry_type           seed;

   assign accept  = start && !busy;
   assign cmd_key = cmd_ff.key[KEY_BITS-1:0];
   assign tail    = c_out[QUEUE_DEPTH-1];
   assign commit  = (state_ff == ST_SWEEP) && tail.valid;

   always_comb begin
      seed            = '0;
      seed.valid      = seed_ff;
      cell_cmd.take      = (cmd_ff.func == FUNC_TAKE);
      cell_cmd.conv      = conv_ff;
      cell_cmd.link      = link_ff;
      cell_cmd.req_id    = net_req_ff;
      cell_cmd.conn_id   = net_conn_ff;
      cell_cmd.prompt_id = cmd_ff.prompt_id;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign c_in[i]  = seed;
         assign fi_in[i] = '0;
         assign si_in[i] = '0;
         assign sk_in[i] = '0;
      end else begin : g_link
         assign c_in[i]  = c_out[i-1];
         assign fi_in[i] = fi_out[i-1];
         assign si_in[i] = si_out[i-1];
         assign sk_in[i] = sk_out[i-1];
      end

      dpq_cell #(
         .KEY_BITS (KEY_BITS),
         .IDX_W    (IDX_W),
         .IDX      (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cell_cmd),
         .cmd_key       (cmd_key),
         .cin           (c_in[i]),
         .cin_free_idx  (fi_in[i]),
         .cin_sel_idx   (si_in[i]),
         .cin_sel_key   (sk_in[i]),
         .cout          (c_out[i]),
         .cout_free_idx (fi_out[i]),
         .cout_sel_idx  (si_out[i]),
         .cout_sel_key  (sk_out[i]),
         .wr            (cell_wr),
         .wr_idx        (wr_idx),
         .used          (used_vec[i])
      );
   end

   // apply the tail of the sweep
   always_comb begin
      pending        = (playing_ff && (playing_tag_ff == cmd_key)) || tail.hit;
      conv_in        = conv_ff;
      link_in        = link_ff;
      playing_in     = playing_ff;
      playing_tag_in = playing_tag_ff;
      last_valid_in  = last_valid_ff;
      last_tag_in    = last_tag_ff;
      last_code_in   = last_code_ff;
      status_in      = STATUS_OK;
      gvalid_in      = 1'b0;
      gid_in         = '0;
      gkey_in        = '0;
      rcode_in       = '0;
      cell_wr        = '0;
      wr_idx         = fi_out[QUEUE_DEPTH-1];

      if (commit) begin
         unique case (func_type'(cmd_ff.func))
            FUNC_SUBMIT: begin
               if (cmd_key == '0) begin
                  status_in = STATUS_EMPTY;
               end else if (!pending) begin
                  if (!tail.free_found) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cell_wr.set = 1'b1;
                  end
               end
            end
            FUNC_TAKE: begin
               wr_idx = si_out[QUEUE_DEPTH-1];
               if (tail.sel_found) begin
                  cell_wr.clr    = 1'b1;
                  gvalid_in      = 1'b1;
                  gid_in         = tail.sel_id;
                  gkey_in        = KEY_W'(sk_out[QUEUE_DEPTH-1]);
                  playing_in     = 1'b1;
                  playing_tag_in = sk_out[QUEUE_DEPTH-1];
               end
            end
            FUNC_DONE: begin
               if (playing_ff) begin
                  last_code_in   = cmd_ff.play_result;
                  last_valid_in  = 1'b1;
                  last_tag_in    = playing_tag_ff;
                  playing_in     = 1'b0;
                  playing_tag_in = '0;
               end
            end
            FUNC_SET_CONV: conv_in = cmd_ff.flag_value;
            FUNC_SET_NET:  link_in = cmd_ff.flag_value;
            FUNC_QUERY: begin
               if (cmd_key == '0) begin
                  status_in = STATUS_EMPTY;
               end else if (pending) begin
                  status_in = STATUS_PENDING;
               end else if (last_valid_ff && (last_tag_ff == cmd_key)) begin
                  rcode_in = last_code_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SWEEP;
         ST_SWEEP: if (tail.valid) state_in = ST_DONE;
         ST_DONE:  state_in = start ? ST_SWEEP : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seed_ff        <= 1'b0;
         net_req_ff     <= NET_REQUIRED_RESET;
         net_conn_ff    <= NET_CONNECTED_RESET;
         conv_ff        <= 1'b0;
         link_ff        <= 1'b0;
         playing_ff     <= 1'b0;
         playing_tag_ff <= '0;
         last_valid_ff  <= 1'b0;
         last_tag_ff    <= '0;
         last_code_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         seed_ff        <= accept;
         conv_ff        <= conv_in;
         link_ff        <= link_in;
         playing_ff     <= playing_in;
         playing_tag_ff <= playing_tag_in;
         last_valid_ff  <= last_valid_in;
         last_tag_ff    <= last_tag_in;
         last_code_ff   <= last_code_in;
         if (csr_we) begin
            if (csr_index == CSR_NET_REQUIRED) begin
               net_req_ff <= csr_wdata;
            end else if (csr_index == CSR_NET_CONNECTED) begin
               net_conn_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data;
      end
      if (commit) begin
         status_ff <= status_in;
         gvalid_ff <= gvalid_in;
         gid_ff    <= gid_in;
         gkey_ff   <= gkey_in;
         rcode_ff  <= rcode_in;
      end
   end

   assign busy      = (state_ff == ST_SWEEP);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = '{
      status:      status_ff,
      grant_valid: gvalid_ff,
      grant_id:    gid_ff,
      grant_key:   gkey_ff,
      result_code: rcode_ff,
      busy_res:    playing_ff || (|used_vec)
   };

   `DPQ_ASSERT_NOW(a_rsp_not_busy, rsp_valid, !busy, "result beat while sweep active")
   `DPQ_ASSERT_NEXT(a_accept_starts, accept, busy, "accepted beat did not start sweep")
   `DPQ_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe held twice")
   `DPQ_ASSERT_NOW(a_grant_busy, rsp_valid && rsp_data.grant_valid, rsp_data.busy_res,
                   "grant without playing state")

endmodule
